// ----- hdl/bit_pkg.sv -----
// package: types, constants and neighborhood test for the thinning core
package bit_pkg;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int ADDR_W = COL_W + ROW_W;
    localparam logic [7:0] BG_LEVEL = 8'd255;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_THIN = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] pixel_in;
    } t_req;

    typedef struct packed {
        logic [7:0]  pixel_out;
        logic [15:0] passes;
    } t_rsp;

    // 3x3 window: bits {nw,n,ne,w,c,e,sw,s,se}
    function automatic logic guo_hall_mark(input logic [8:0] win, input logic second);
        logic nw, n, ne, wv, cc, e, sw, s, se;
        logic [2:0] conn, n1, n2, nn;
        logic m;
        {nw, n, ne, wv, cc, e, sw, s, se} = win;
        conn = 3'(~n & (ne | e)) + 3'(~e & (se | s)) + 3'(~s & (sw | wv)) + 3'(~wv & (nw | n));
        n1 = 3'(nw | n) + 3'(ne | e) + 3'(se | s) + 3'(sw | wv);
        n2 = 3'(n | ne) + 3'(e | se) + 3'(s | sw) + 3'(wv | nw);
        nn = (n1 < n2) ? n1 : n2;
        m = second ? ((n | ne | ~se) & e) : ((s | sw | ~nw) & wv);
        return cc && conn == 3'd1 && nn >= 3'd2 && nn <= 3'd3 && !m;
    endfunction
endpackage

// ----- hdl/bit_regs.sv -----
// configuration registers on the apb-style port
module bit_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [8:0]  o_width,
    output logic [8:0]  o_height,
    output logic [7:0]  o_thresh
);
    import bit_pkg::*;
    logic [8:0] r_width, r_height;
    logic [7:0] r_thresh;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
            r_thresh <= 8'd127;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_WIDTH:  r_width  <= pwdata[8:0];
                REG_HEIGHT: r_height <= pwdata[8:0];
                REG_THRESH: r_thresh <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_WIDTH:  prdata = {23'd0, r_width};
            REG_HEIGHT: prdata = {23'd0, r_height};
            REG_THRESH: prdata = {24'd0, r_thresh};
            default:    prdata = '0;
        endcase
    end

    assign o_width  = r_width;
    assign o_height = r_height;
    assign o_thresh = r_thresh;
endmodule

// ----- hdl/binary_image_thinning_core.sv -----
// top level: guo-hall thinning core with frame bit memory and sweep sequencer
// Load (mode 0) and read (mode 2) requests leave busy low, and their result
// strobes in the cycle after start. A thinning request (mode 1) holds
// busy high while the sequencer sweeps the frame bit memory. Each subiteration
// takes two sweeps, one pixel at a time since the memory has a single read port:
// a mark sweep, which reads the nine window bits and writes the mark for each
// interior pixel, and a clear sweep that clears each marked interior pixel.
// The run repeats pairs of subiterations until one pair removes nothing; the
// sequencer then passes through its done state, from which the result strobe
// is registered. The receiver cannot stall: each result is shown for exactly one
// cycle on o_valid.
module binary_image_thinning_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  bit_pkg::t_req   i_req,
    output logic            o_valid,
    output bit_pkg::t_rsp   o_rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import bit_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MARK = 3'd1; // read window bit by bit
    localparam logic [2:0] S_MEVAL = 3'd2; // last window bit back, write mark
    localparam logic [2:0] S_CRD  = 3'd3; // read mark
    localparam logic [2:0] S_CWR  = 3'd4; // clear pixel if marked
    localparam logic [2:0] S_DONE = 3'd5;

    logic [8:0] w_width, w_height;
    logic [7:0] w_thresh;

    bit_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_width(w_width), .o_height(w_height), .o_thresh(w_thresh)
    );

    // effective frame size, saturated into 3..256
    logic [8:0] w_effw, w_effh;
    assign w_effw = (w_width < 9'd3) ? 9'd3 : (w_width > 9'd256) ? 9'd256 : w_width;
    assign w_effh = (w_height < 9'd3) ? 9'd3 : (w_height > 9'd256) ? 9'd256 : w_height;

    // frame and mark bit memories
    logic img_mem [2**ADDR_W];
    logic mrk_mem [2**ADDR_W];

    logic [2:0]  r_state, n_state;
    logic [7:0]  r_r, n_r, r_c, n_c;
    logic [3:0]  r_k, n_k;            // window bit index in mark sweep
    logic [8:0]  r_win, n_win;
    logic        r_second, n_second;
    logic        r_rem, n_rem;        // removed in this pair
    logic [15:0] r_pass, n_pass;
    logic        r_changed, n_changed;
    logic        r_valid, n_valid;
    logic        r_rdsel, n_rdsel;    // result of a read request pending
    logic        r_rdout, n_rdout;    // read pixel was outside
    logic        img_q, mrk_q;

    // memory port controls
    logic             img_we, img_wd, mrk_we, mrk_wd;
    logic [ADDR_W-1:0] img_wa, img_ra, mrk_a;

    always_ff @(posedge i_clk) begin
        if (img_we) img_mem[img_wa] <= img_wd;
        img_q <= img_mem[img_ra];
        if (mrk_we) mrk_mem[mrk_a] <= mrk_wd;
        mrk_q <= mrk_mem[mrk_a];
    end

    // window offset for bit k: rows -1..1, cols -1..1
    logic [7:0] w_wr, w_wc;
    logic [7:0] w_dr, w_dc;           // row and column offset plus one
    always_comb begin
        case (r_k)
            4'd0, 4'd1, 4'd2: w_dr = 8'd0;
            4'd3, 4'd4, 4'd5: w_dr = 8'd1;
            default:          w_dr = 8'd2;
        endcase
        case (r_k)
            4'd0, 4'd3, 4'd6: w_dc = 8'd0;
            4'd1, 4'd4, 4'd7: w_dc = 8'd1;
            default:          w_dc = 8'd2;
        endcase
        w_wr = r_r + w_dr - 8'd1;
        w_wc = r_c + w_dc - 8'd1;
    end

    logic w_in_bounds, w_last_c, w_last_r;
    assign w_in_bounds = {1'b0, i_req.row} < w_effh && {1'b0, i_req.col} < w_effw;
    assign w_last_c = {1'b0, r_c} + 9'd2 >= w_effw;
    assign w_last_r = {1'b0, r_r} + 9'd2 >= w_effh;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state; n_r = r_r; n_c = r_c; n_k = r_k; n_win = r_win;
        n_second = r_second; n_rem = r_rem; n_pass = r_pass; n_changed = r_changed;
        n_valid = 1'b0; n_rdsel = 1'b0; n_rdout = r_rdout;
        img_we = 1'b0; img_wd = 1'b0; img_wa = {r_r, r_c};
        img_ra = {r_r, r_c}; mrk_we = 1'b0; mrk_wd = 1'b0; mrk_a = {r_r, r_c};
        case (r_state)
            S_IDLE: begin
                img_ra = {i_req.row, i_req.col};
                if (start) begin
                    case (i_req.mode)
                        MODE_LOAD: begin
                            img_we = w_in_bounds;
                            img_wa = {i_req.row, i_req.col};
                            img_wd = {1'b0, i_req.pixel_in} <= {1'b0, w_thresh};
                            n_valid = 1'b1;
                        end
                        MODE_THIN: begin
                            n_pass = '0; n_r = 8'd1; n_c = 8'd1; n_k = '0;
                            n_second = 1'b0; n_rem = 1'b0; n_state = S_MARK;
                        end
                        MODE_READ: begin
                            n_valid = 1'b1; n_rdsel = 1'b1; n_rdout = !w_in_bounds;
                        end
                        default: n_valid = 1'b1;
                    endcase
                end
            end
            S_MARK: begin
                img_ra = {w_wr, w_wc};
                if (r_k != 4'd0) n_win = {r_win[7:0], img_q};
                n_k = r_k + 4'd1;
                if (r_k == 4'd8) n_state = S_MEVAL;
            end
            S_MEVAL: begin
                mrk_we = 1'b1;
                mrk_wd = guo_hall_mark({r_win[7:0], img_q}, r_second);
                n_k = '0;
                if (w_last_c) begin
                    n_c = 8'd1;
                    if (w_last_r) begin
                        n_r = 8'd1; n_state = S_CRD;
                    end else begin
                        n_r = r_r + 8'd1; n_state = S_MARK;
                    end
                end else begin
                    n_c = r_c + 8'd1; n_state = S_MARK;
                end
            end
            S_CRD: n_state = S_CWR;
            S_CWR: begin
                if (mrk_q) begin
                    img_we = 1'b1; img_wd = 1'b0; n_rem = 1'b1;
                end
                n_state = S_CRD;
                if (w_last_c) begin
                    n_c = 8'd1;
                    if (w_last_r) begin
                        n_r = 8'd1;
                        if (r_second) begin
                            n_changed = r_rem || mrk_q;
                            if (r_pass != 16'hFFFF) n_pass = r_pass + 16'd1;
                            n_second = 1'b0; n_rem = 1'b0;
                            n_state = (r_rem || mrk_q) ? S_MARK : S_DONE;
                        end else begin
                            n_second = 1'b1; n_state = S_MARK;
                        end
                    end else n_r = r_r + 8'd1;
                end else n_c = r_c + 8'd1;
            end
            S_DONE: begin
                n_valid = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_pass <= '0; r_changed <= 1'b0;
            r_valid <= 1'b0; r_rdsel <= 1'b0;
        end else begin
            r_state <= n_state; r_pass <= n_pass; r_changed <= n_changed;
            r_valid <= n_valid; r_rdsel <= n_rdsel;
        end
        r_r <= n_r; r_c <= n_c; r_k <= n_k; r_win <= n_win;
        r_second <= n_second; r_rem <= n_rem; r_rdout <= n_rdout;
    end

    assign o_valid = r_valid;
    assign o_rsp.passes = r_pass;
    assign o_rsp.pixel_out = (r_rdsel && (r_rdout || !img_q)) ? BG_LEVEL : 8'd0;

`ifndef NO_ASSERTIONS
    a_busy_no_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK || r_state == S_CRD) |-> !o_valid) else $error("strobe in sweep");
    a_read_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rdsel |-> r_valid) else $error("read result without strobe");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_state == S_IDLE && o_valid) else $error("done");
`endif
endmodule

// ----- tb/binary_image_thinning_core_test.sv -----
// testbench: guo-hall thinning core checked against a behavioral thinning predictor
`timescale 1ns / 1ps

module binary_image_thinning_core_test;
    import bit_pkg::*;

    // mode value that the core treats as a no-op
    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int SMALL_MAX = 12;

    typedef enum logic { ROW_REQ, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind  kind;
        t_req       req;
        bit         typed;
        t_rsp       want;
        logic [1:0] reg_idx;
        int         reg_val;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        o_valid;
    t_rsp        o_rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    binary_image_thinning_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state: frame bits, deletion marks, pass count and registers
    bit          frame_bits [MAX_WIDTH*MAX_HEIGHT];
    bit          del_marks  [MAX_WIDTH*MAX_HEIGHT];
    bit          loaded     [MAX_WIDTH*MAX_HEIGHT];
    int          loaded_list[$];
    logic [15:0] pair_count;
    logic [8:0]  cfg_width;
    logic [8:0]  cfg_height;
    logic [7:0]  cfg_thresh;

    t_rsp        pending_rsp[$];
    int          errors;
    int          items;
    int          idle_pct;
    int          quiet_cycles;

    initial begin
        i_clk = 1'b0;
    end
    always #10 i_clk = ~i_clk;

    function automatic int width_in_use();
        if (cfg_width < 3) return 3;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int height_in_use();
        if (cfg_height < 3) return 3;
        if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
        return cfg_height;
    endfunction

    function automatic int pix(int r, int c);
        return frame_bits[r*MAX_WIDTH + c];
    endfunction

    // one parallel subiteration: mark from the current frame, then clear all marked pixels
    function automatic bit thin_sweep(bit second);
        int  w, h, conn, n1, n2, nn, m;
        int  nw, n, ne, e, se, s, sw, wv;
        bit  removed;
        w = width_in_use();
        h = height_in_use();
        removed = 1'b0;
        for (int r = 1; r + 1 < h; r++) begin
            for (int c = 1; c + 1 < w; c++) begin
                nw = pix(r-1, c-1); n = pix(r-1, c); ne = pix(r-1, c+1);
                e  = pix(r, c+1);   se = pix(r+1, c+1); s = pix(r+1, c);
                sw = pix(r+1, c-1); wv = pix(r, c-1);
                conn = ((1-n) & (ne|e)) + ((1-e) & (se|s)) + ((1-s) & (sw|wv))
                     + ((1-wv) & (nw|n));
                n1 = (nw|n) + (ne|e) + (se|s) + (sw|wv);
                n2 = (n|ne) + (e|se) + (s|sw) + (wv|nw);
                nn = (n1 < n2) ? n1 : n2;
                m = second ? ((n | ne | (1-se)) & e) : ((s | sw | (1-nw)) & wv);
                del_marks[r*MAX_WIDTH + c] = pix(r, c) && conn == 1 && nn >= 2 && nn <= 3
                                             && m == 0;
            end
        end
        for (int r = 1; r + 1 < h; r++) begin
            for (int c = 1; c + 1 < w; c++) begin
                if (del_marks[r*MAX_WIDTH + c]) begin
                    frame_bits[r*MAX_WIDTH + c] = 1'b0;
                    removed = 1'b1;
                end
            end
        end
        return removed;
    endfunction

    function automatic void thin_frame();
        bit a, b;
        pair_count = '0;
        do begin
            a = thin_sweep(1'b0);
            b = thin_sweep(1'b1);
            if (pair_count != 16'hffff) pair_count++;
        end while (a || b);
    endfunction

    function automatic t_rsp predict_response(t_req q);
        t_rsp rsp;
        bit   in_frame;
        int   addr;
        in_frame = q.row < height_in_use() && q.col < width_in_use();
        addr = q.row*MAX_WIDTH + q.col;
        rsp.pixel_out = 8'd0;
        case (q.mode)
            MODE_LOAD: begin
                if (in_frame) begin
                    frame_bits[addr] = (q.pixel_in <= cfg_thresh);
                    if (!loaded[addr]) loaded_list.push_back(addr);
                    loaded[addr] = 1'b1;
                end
            end
            MODE_THIN: thin_frame();
            MODE_READ: rsp.pixel_out = (in_frame && frame_bits[addr]) ? 8'd0 : BG_LEVEL;
            default: ;
        endcase
        rsp.passes = pair_count;
        return rsp;
    endfunction

    task automatic report(string what, int want, int got);
        errors++;
        $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    endtask

    // result checker; the receiver cannot stall so every strobe is taken
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid) begin
            if (pending_rsp.size() == 0) begin
                report("unexpected result, pixel_out", -1, o_rsp.pixel_out);
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.pixel_out !== want.pixel_out)
                    report("pixel_out", want.pixel_out, o_rsp.pixel_out);
                if (o_rsp.passes !== want.passes)
                    report("passes", want.passes, o_rsp.passes);
            end
        end
    end

    // watchdog on cycles in which no request and no result is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // hold start high until the core takes the request, then maybe go idle
    task automatic send_request(t_req q, bit typed, t_rsp want);
        t_rsp guess;
        i_req <= q;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        guess = predict_response(q);
        pending_rsp.push_back(typed ? want : guess);
        items++;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_fields(logic [1:0] mode, int r, int c, int grey);
        t_req q;
        t_rsp none;
        q.mode = mode;
        q.row = r[7:0];
        q.col = c[7:0];
        q.pixel_in = grey[7:0];
        none = '0;
        send_request(q, 1'b0, none);
    endtask

    // sender pause: everything expected has come and the core is idle
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_rsp.size() != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_width  = value[8:0];
            REG_HEIGHT: cfg_height = value[8:0];
            REG_THRESH: cfg_thresh = value[7:0];
            default: ;
        endcase
    endtask

    // grey level that lands on the wanted side of the threshold where possible
    function automatic int pick_grey(bit fg);
        if (fg) return $urandom_range(cfg_thresh, 0);
        if (cfg_thresh == 8'd255) return 255;
        return $urandom_range(255, cfg_thresh + 1);
    endfunction

    // read of a loaded in-frame pixel, or of a point outside the frame
    task automatic read_somewhere();
        int r, c, addr;
        r = $urandom_range(255);
        c = $urandom_range(255);
        if (r < height_in_use() && c < width_in_use() && !loaded[r*MAX_WIDTH + c]) begin
            addr = loaded_list[$urandom_range(loaded_list.size() - 1)];
            r = addr / MAX_WIDTH;
            c = addr % MAX_WIDTH;
        end
        send_fields(MODE_READ, r, c, $urandom_range(255));
    endtask

    // random frame: a small one is filled, noised, thinned and read back; a big one gets loads and reads
    task automatic frame_phase();
        int w, h, density, pick;
        pick = $urandom_range(9);
        if (pick == 0)      write_reg(REG_WIDTH, $urandom_range(2));
        else if (pick == 1) write_reg(REG_WIDTH, $urandom_range(511, 257));
        else                write_reg(REG_WIDTH, $urandom_range(SMALL_MAX, 3));
        pick = $urandom_range(9);
        if (pick == 0)      write_reg(REG_HEIGHT, $urandom_range(2));
        else if (pick == 1) write_reg(REG_HEIGHT, 256);
        else                write_reg(REG_HEIGHT, $urandom_range(SMALL_MAX, 3));
        pick = $urandom_range(5);
        write_reg(REG_THRESH, pick == 0 ? 0 : pick == 1 ? 255 : $urandom_range(255));
        w = width_in_use();
        h = height_in_use();

        if (w > SMALL_MAX || h > SMALL_MAX) begin
            // big frame: loads and reads anywhere, never a thinning run
            repeat (30) begin
                pick = $urandom_range(9);
                if (pick < 5)       send_fields(MODE_LOAD, $urandom_range(255),
                                                $urandom_range(255), $urandom_range(255));
                else if (pick < 9)  read_somewhere();
                else                send_fields(MODE_NOP, $urandom_range(255),
                                                $urandom_range(255), $urandom_range(255));
            end
        end else begin
            density = $urandom_range(90, 30);
            for (int r = 0; r < h; r++)
                for (int c = 0; c < w; c++)
                    send_fields(MODE_LOAD, r, c, pick_grey($urandom_range(99) < density));
            // noise: out-of-frame loads, reads, no-ops and reloads
            repeat ($urandom_range(8, 2)) begin
                pick = $urandom_range(3);
                case (pick)
                    0: send_fields(MODE_LOAD, $urandom_range(255, h), $urandom_range(255),
                                   $urandom_range(255));
                    1: read_somewhere();
                    2: send_fields(MODE_NOP, $urandom_range(255), $urandom_range(255),
                                   $urandom_range(255));
                    default: send_fields(MODE_LOAD, $urandom_range(h - 1),
                                         $urandom_range(w - 1), $urandom_range(255));
                endcase
            end
            send_fields(MODE_THIN, $urandom_range(255), $urandom_range(255),
                        $urandom_range(255));
            repeat ($urandom_range(10, 4)) read_somewhere();
            // a second run on a thinned frame removes nothing more
            if ($urandom_range(3) == 0)
                send_fields(MODE_THIN, 0, 0, 0);
        end
    endtask

    // directed rows: extremes after reset, a 3x3 frame from saturated sizes,
    // out-of-frame load and read, and the no-op mode
    t_row directed [] = '{
        '{ROW_REQ, '{MODE_LOAD, 8'd0,   8'd0,   8'd127}, 1, '{8'd0,   16'd0}, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_LOAD, 8'd255, 8'd255, 8'd128}, 1, '{8'd0,   16'd0}, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_LOAD, 8'd0,   8'd255, 8'd0},   1, '{8'd0,   16'd0}, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_LOAD, 8'd255, 8'd0,   8'd255}, 1, '{8'd0,   16'd0}, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_READ, 8'd0,   8'd0,   8'd255}, 1, '{8'd0,   16'd0}, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_READ, 8'd255, 8'd255, 8'd0},   1, '{8'd255, 16'd0}, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_READ, 8'd0,   8'd255, 8'd0},   1, '{8'd0,   16'd0}, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_READ, 8'd255, 8'd0,   8'd0},   1, '{8'd255, 16'd0}, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_NOP,  8'd9,   8'd9,   8'd9},   1, '{8'd0,   16'd0}, REG_WIDTH, 0},
        '{ROW_CFG, '0, 0, '0, REG_WIDTH,  0},
        '{ROW_CFG, '0, 0, '0, REG_HEIGHT, 2},
        '{ROW_CFG, '0, 0, '0, REG_THRESH, 0},
        '{ROW_REQ, '{MODE_LOAD, 8'd0, 8'd0, 8'd0}, 0, '0, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_LOAD, 8'd0, 8'd1, 8'd0}, 0, '0, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_LOAD, 8'd0, 8'd2, 8'd0}, 0, '0, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_LOAD, 8'd1, 8'd0, 8'd0}, 0, '0, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_LOAD, 8'd1, 8'd1, 8'd0}, 0, '0, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_LOAD, 8'd1, 8'd2, 8'd0}, 0, '0, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_LOAD, 8'd2, 8'd0, 8'd0}, 0, '0, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_LOAD, 8'd2, 8'd1, 8'd0}, 0, '0, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_LOAD, 8'd2, 8'd2, 8'd1}, 0, '0, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_LOAD, 8'd5, 8'd5, 8'd0}, 0, '0, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_THIN, 8'd0, 8'd0, 8'd0}, 0, '0, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_READ, 8'd1, 8'd1, 8'd0}, 0, '0, REG_WIDTH, 0},
        '{ROW_REQ, '{MODE_READ, 8'd5, 8'd5, 8'd0}, 1, '{8'd255, 16'd1}, REG_WIDTH, 0}
    };

    initial begin
        int idle_plan [3] = '{0, 50, 25};
        int quota;
        errors = 0;
        items = 0;
        idle_pct = 0;
        quiet_cycles = 0;
        pair_count = '0;
        cfg_width = 9'd256;
        cfg_height = 9'd256;
        cfg_thresh = 8'd127;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            if (directed[k].kind == ROW_CFG)
                write_reg(directed[k].reg_idx, directed[k].reg_val);
            else
                send_request(directed[k].req, directed[k].typed, directed[k].want);
        end

        // random frames under each idling plan in turn
        for (int p = 0; p < 3; p++) begin
            idle_pct = idle_plan[p];
            quota = 700 * (p + 1) / 3;
            while (items < quota) frame_phase();
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (pending_rsp.size() != 0) report("results left over", 0, pending_rsp.size());
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hdl/bit_pkg.sv
hdl/bit_regs.sv
hdl/binary_image_thinning_core.sv
tb/binary_image_thinning_core_test.sv
